// ===== rtl/pcs_pkg.sv =====
// Shared types, constants and helper functions for the configuration space block.
// Used by every module under rtl/ except pcs_ram.
package pcs_pkg;

   localparam int SPACE_BYTES_DEFAULT = 256;
   localparam int NUM_BARS = 6;
   localparam int LANES = 4;
   localparam int REGION_BITS = 14;
   localparam int CSR_DATA_BITS = 56;
   localparam int CSR_INDEX_BITS = 3;
   localparam int BAR_LOW_BITS = 56;
   localparam int BAR_HIGH_BITS = 42;
   localparam int SETUP_BITS = BAR_LOW_BITS + BAR_HIGH_BITS;
   localparam int REQ_DATA_BITS = 48;
   localparam int RSP_DATA_BITS = 40;

   localparam logic [2:0] ROM_SLOT = 3'd6;
   localparam logic [2:0] LEN_FULL = 3'd4;

   localparam logic [7:0] BAR_BASE = 8'h10;
   localparam logic [8:0] BAR_END = 9'(16 + 4 * NUM_BARS);
   localparam logic [7:0] ROM_BASE = 8'h30;
   localparam logic [7:0] ROM_END = 8'h34;
   localparam logic [8:0] CMD_REG = 9'h004;
   localparam logic [7:0] CMD_REG_END = 8'h06;
   localparam logic [8:0] HDR_KIND_ADDR = 9'h00e;
   localparam logic [8:0] INT_PIN_ADDR = 9'h03d;
   localparam logic [8:0] IDENT_LAST = 9'h003;
   localparam logic [8:0] CLASS_FIRST = 9'h008;
   localparam logic [8:0] CLASS_LAST = 9'h00b;
   localparam logic [8:0] DEV_RO_FIRST = 9'h010;
   localparam logic [8:0] DEV_RO_LAST = 9'h027;
   localparam logic [8:0] ROM_RO_FIRST = 9'h030;
   localparam logic [8:0] ROM_RO_LAST = 9'h033;
   localparam logic [8:0] BRG_RO_FIRST = 9'h038;
   localparam logic [8:0] BRG_RO_LAST = 9'h03b;
   localparam logic [7:0] KIND_DEVICE = 8'h00;
   localparam logic [7:0] KIND_DEVICE_MF = 8'h80;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IDENTITY = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLASS = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HDR_KIND = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INT_PIN = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BAR_LOW = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BAR_HIGH = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_LOAD
   } pcs_state_type;

   typedef struct packed {
      logic        acc;
      logic        wr;
      logic        done;
      logic [7:0]  addr;
      logic [2:0]  len;
      logic [31:0] word;
      logic [7:0]  header_kind;
   } lane_ctrl_type;

   typedef struct packed {
      logic [31:0] identity_word;
      logic [31:0] class_word;
      logic [7:0]  header_kind;
      logic [7:0]  interrupt_pin;
   } reg_view_type;

   function automatic logic byte_read_only(logic [8:0] a, logic [7:0] kind);
      logic fixed_ro;
      logic dev_ro;
      logic brg_ro;
      fixed_ro = (a <= IDENT_LAST) || (a >= CLASS_FIRST && a <= CLASS_LAST) ||
                 (a == HDR_KIND_ADDR) || (a == INT_PIN_ADDR);
      dev_ro = (a >= DEV_RO_FIRST && a <= DEV_RO_LAST) ||
               (a >= ROM_RO_FIRST && a <= ROM_RO_LAST);
      brg_ro = (a >= BRG_RO_FIRST && a <= BRG_RO_LAST);
      if (fixed_ro) begin
         return 1'b1;
      end else if (kind == KIND_DEVICE || kind == KIND_DEVICE_MF) begin
         return dev_ro;
      end else begin
         return brg_ro;
      end
   endfunction

   // size code n means 2^(n-1) bytes; regions of 4 GiB and up keep no bits
   function automatic logic [31:0] size_mask(logic [5:0] code);
      logic [5:0] sh;
      sh = code - 6'd1;
      if (code == 6'd0 || sh > 6'd31) begin
         return 32'h0;
      end else begin
         return 32'hFFFF_FFFF << sh[4:0];
      end
   endfunction

endpackage

// ===== rtl/pci_config_space_write_mask_top.sv =====
// Configuration space with BAR/ROM write masking: four byte lanes and a merge stage.
// An accepted request passes the access state (lane RAM read) and then the load state,
// which holds while a response awaits rsp_tready; one word is in flight at a time.
// Reset (synchronous, active high) clears control, config registers and the per-byte
// valid bits; unwritten store bytes read as zero, so there is no clearing pass.
// Depends on pcs_pkg, pcs_lane, pcs_ram and pcs_merge.
module pci_config_space_write_mask_top import pcs_pkg::*; #(
   parameter int SPACE_BYTES = SPACE_BYTES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,   // address[7:0], value[39:8], length[42:40]
   input  logic                      req_tuser,   // command
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,   // read_data[31:0], mappings_update[32]
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   pcs_state_type state_ff, state_in;

   logic [31:0]            identity_ff;
   logic [31:0]            class_ff;
   logic [7:0]             hdr_kind_ff;
   logic [7:0]             int_pin_ff;
   logic [BAR_LOW_BITS-1:0]  bar_low_ff;
   logic [BAR_HIGH_BITS-1:0] bar_high_ff;

   logic        cmd_ff;
   logic [7:0]  addr_ff;
   logic [31:0] val_ff;
   logic [2:0]  len_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff;
   logic        rsp_flag_ff;

   logic        accept;
   logic        acc;
   logic        load_go;
   logic [2:0]  len_sat;
   logic        in_rom;
   logic        in_bar;
   logic [2:0]  slot;
   logic [SETUP_BITS-1:0]  setup;
   logic [REGION_BITS-1:0] field;
   logic [31:0] mask;
   logic [31:0] masked;
   logic        done;
   logic        flag;
   logic [31:0] merged;

   lane_ctrl_type          ctrl;
   reg_view_type           regs;
   logic [LANES-1:0][7:0]  lane_bytes;

   assign accept = req_tvalid & req_tready;
   assign csr_ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ACCESS;
            end
         end
         ST_ACCESS: state_in = ST_LOAD;
         ST_LOAD: begin
            if (load_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      acc = 1'b0;
      load_go = 1'b0;
      case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_ACCESS: acc = 1'b1;
         ST_LOAD:   load_go = ~rsp_valid_ff | rsp_tready;
         default:   req_tready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         identity_ff <= '0;
         class_ff <= '0;
         hdr_kind_ff <= '0;
         int_pin_ff <= '0;
         bar_low_ff <= '0;
         bar_high_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_IDENTITY: identity_ff <= csr_data[31:0];
               CSR_CLASS:    class_ff <= csr_data[31:0];
               CSR_HDR_KIND: hdr_kind_ff <= csr_data[7:0];
               CSR_INT_PIN:  int_pin_ff <= csr_data[7:0];
               CSR_BAR_LOW:  bar_low_ff <= csr_data[BAR_LOW_BITS-1:0];
               CSR_BAR_HIGH: bar_high_ff <= csr_data[BAR_HIGH_BITS-1:0];
               default:      ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_tuser;
         addr_ff <= req_tdata[7:0];
         val_ff <= req_tdata[39:8];
         len_ff <= req_tdata[42:40];
      end
   end

   // BAR / ROM masking of a full-word write and the mappings-update flag
   assign len_sat = (len_ff > LEN_FULL) ? LEN_FULL : len_ff;
   assign in_rom = (addr_ff >= ROM_BASE) && (addr_ff < ROM_END);
   assign in_bar = (addr_ff >= BAR_BASE) && ({1'b0, addr_ff} < BAR_END);
   assign slot = in_rom ? ROM_SLOT : 3'((addr_ff - BAR_BASE) >> 2);
   assign setup = {bar_high_ff, bar_low_ff};
   assign field = setup[7'(slot) * 7'(REGION_BITS) +: REGION_BITS];
   assign mask = size_mask(field[5:0]);
   assign masked = in_rom ? (val_ff & (mask | 32'h1))
                          : ((val_ff & mask) | {24'h0, field[13:6]});
   assign done = ~cmd_ff && (len_sat == LEN_FULL) && (in_rom || in_bar) &&
                 (field[5:0] != 6'd0);
   assign flag = ~cmd_ff && (done || ((len_sat != 3'd0) &&
                 (({1'b0, addr_ff} + 9'(len_sat)) > CMD_REG) && (addr_ff < CMD_REG_END)));

   assign ctrl = '{
      acc:         acc,
      wr:          ~cmd_ff,
      done:        done,
      addr:        addr_ff,
      len:         len_sat,
      word:        done ? masked : val_ff,
      header_kind: hdr_kind_ff
   };

   assign regs = '{
      identity_word: identity_ff,
      class_word:    class_ff,
      header_kind:   hdr_kind_ff,
      interrupt_pin: int_pin_ff
   };

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      pcs_lane #(
         .LANE        (g),
         .SPACE_BYTES (SPACE_BYTES)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .regs    (regs),
         .rd_byte (lane_bytes[g])
      );
   end

   pcs_merge u_merge (
      .lane_bytes (lane_bytes),
      .addr_lo    (addr_ff[1:0]),
      .is_read    (cmd_ff),
      .read_data  (merged)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_go) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_go) begin
         rsp_data_ff <= merged;
         rsp_flag_ff <= flag;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'h00, rsp_flag_ff, rsp_data_ff};

   a_accept_seq: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_ACCESS) ##1 (state_ff == ST_LOAD))
      else $error("accepted word did not move through access and load");

   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      (load_go && !cmd_ff) |=> (rsp_tdata[31:0] == 32'h0))
      else $error("write response carries nonzero read data");

   a_read_noflag: assert property (@(posedge clock) disable iff (reset)
      (load_go && cmd_ff) |=> !rsp_tdata[32])
      else $error("read response raised mappings update");

endmodule

// ===== rtl/pcs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pcs_lane.sv =====
// One byte lane of configuration space: bytes whose offset mod 4 equals LANE.
// Depends on pcs_pkg and pcs_ram.
module pcs_lane import pcs_pkg::*; #(
   parameter int LANE = 0,
   parameter int SPACE_BYTES = SPACE_BYTES_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  lane_ctrl_type ctrl,
   input  reg_view_type  regs,
   output logic [7:0]    rd_byte
);

   localparam int ROWS = (SPACE_BYTES + LANES - 1) / LANES;
   localparam int RW = $clog2(ROWS);

   logic [1:0]      off;
   logic [8:0]      a;
   logic            in_space;
   logic [RW-1:0]   row;
   logic            we;
   logic            re;
   logic [7:0]      wdata;
   logic [7:0]      ram_q;
   logic [ROWS-1:0] valid_ff;
   logic [ROWS-1:0] valid_in;
   logic            valid_rd_ff;
   logic [8:0]      a_ff;

   assign off = 2'(2'(LANE) - ctrl.addr[1:0]);
   assign a = {1'b0, ctrl.addr} + 9'(off);
   assign in_space = a < 9'(SPACE_BYTES);
   assign row = a[RW+1:2];
   assign wdata = 8'(ctrl.word >> {off, 3'b000});
   assign re = ctrl.acc & ~ctrl.wr;
   assign we = ctrl.acc & ctrl.wr & in_space &
               (ctrl.done | (({1'b0, off} < ctrl.len) & ~byte_read_only(a, ctrl.header_kind)));

   always_comb begin
      valid_in = valid_ff;
      if (we) begin
         valid_in[row] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         valid_rd_ff <= in_space & valid_ff[row];
         a_ff <= a;
      end
   end

   pcs_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (row),
      .wr_data (wdata),
      .rd_en   (re),
      .rd_addr (row),
      .rd_data (ram_q)
   );

   always_comb begin
      if (a_ff <= IDENT_LAST) begin
         rd_byte = 8'(regs.identity_word >> {a_ff[1:0], 3'b000});
      end else if (a_ff >= CLASS_FIRST && a_ff <= CLASS_LAST) begin
         rd_byte = 8'(regs.class_word >> {a_ff[1:0], 3'b000});
      end else if (a_ff == HDR_KIND_ADDR) begin
         rd_byte = regs.header_kind;
      end else if (a_ff == INT_PIN_ADDR) begin
         rd_byte = regs.interrupt_pin;
      end else if (valid_rd_ff) begin
         rd_byte = ram_q;
      end else begin
         rd_byte = 8'h00;
      end
   end

endmodule

// ===== rtl/pcs_merge.sv =====
// Merges the four lane bytes into the read word, lowest byte from the start offset; writes give zero.
// Depends on pcs_pkg.
module pcs_merge import pcs_pkg::*; (
   input  logic [LANES-1:0][7:0] lane_bytes,
   input  logic [1:0]            addr_lo,
   input  logic                  is_read,
   output logic [31:0]           read_data
);

   always_comb begin
      read_data = '0;
      for (int i = 0; i < LANES; i++) begin
         read_data[8*i +: 8] = is_read ? lane_bytes[2'(addr_lo + 2'(i))] : 8'h00;
      end
   end

endmodule

// ===== tb/pcs_access_checker.sv =====
// Access checker for the configuration space block: tracks config writes and accepted
// requests, keeps its own copy of the 256-byte space and compares every response word.
// Depends on pcs_pkg.
module pcs_access_checker import pcs_pkg::*; #(
   parameter int SPACE_BYTES = SPACE_BYTES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,   // address[7:0], value[39:8], length[42:40]
   input  logic                      req_tuser,   // command
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_DATA_BITS-1:0]  rsp_tdata,   // read_data[31:0], mappings_update[32]
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                        errors,
   output int                        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        update;
      logic [31:0] read_data;
   } access_reply_type;

   logic [7:0]  space_mem [0:255];
   logic [31:0] ident_q;
   logic [31:0] class_q;
   logic [7:0]  kind_q;
   logic [7:0]  pin_q;
   logic [BAR_LOW_BITS-1:0]  bar_low_q;
   logic [BAR_HIGH_BITS-1:0] bar_high_q;
   access_reply_type replies_due [$];

   function automatic logic [REGION_BITS-1:0] region_setup(int slot);
      if (slot < 4) begin
         return REGION_BITS'(bar_low_q >> (REGION_BITS * slot));
      end
      return REGION_BITS'(bar_high_q >> (REGION_BITS * (slot - 4)));
   endfunction

   function automatic logic locked_byte(logic [8:0] a);
      if (a <= IDENT_LAST || (a >= CLASS_FIRST && a <= CLASS_LAST) ||
          a == HDR_KIND_ADDR || a == INT_PIN_ADDR) begin
         return 1'b1;
      end
      if (kind_q == KIND_DEVICE || kind_q == KIND_DEVICE_MF) begin
         return (a >= DEV_RO_FIRST && a <= DEV_RO_LAST) ||
                (a >= ROM_RO_FIRST && a <= ROM_RO_LAST);
      end
      return a >= BRG_RO_FIRST && a <= BRG_RO_LAST;
   endfunction

   function automatic logic [7:0] peek(logic [8:0] a);
      if (a <= IDENT_LAST) return ident_q[8*a[1:0] +: 8];
      if (a >= CLASS_FIRST && a <= CLASS_LAST) return class_q[8*a[1:0] +: 8];
      if (a == HDR_KIND_ADDR) return kind_q;
      if (a == INT_PIN_ADDR) return pin_q;
      if (a < SPACE_BYTES && a < 256) return space_mem[a[7:0]];
      return 8'h00;
   endfunction

   task automatic apply_access(input logic is_read, input logic [7:0] addr,
                               input logic [31:0] val, input logic [2:0] len,
                               output access_reply_type r);
      logic [2:0]  n;
      int          slot;
      logic [REGION_BITS-1:0] f;
      logic [5:0]  code;
      logic [63:0] low_ones;
      logic [31:0] keep;
      logic [31:0] w;
      logic [8:0]  a;
      logic        masked;
      r = '0;
      if (is_read) begin
         for (int i = 0; i < LANES; i++) begin
            r.read_data[8*i +: 8] = peek(9'(addr) + 9'(i));
         end
      end else begin
         n = (len > LEN_FULL) ? LEN_FULL : len;
         masked = 1'b0;
         slot = -1;
         if (n == LEN_FULL) begin
            if (addr >= ROM_BASE && addr < ROM_END) begin
               slot = ROM_SLOT;
            end else if (addr >= BAR_BASE && 9'(addr) < BAR_END) begin
               slot = (addr - BAR_BASE) >> 2;
            end
            if (slot >= 0) begin
               f = region_setup(slot);
               code = f[5:0];
               if (code != 6'd0) begin
                  low_ones = (64'd1 << (code - 6'd1)) - 64'd1;
                  keep = ~low_ones[31:0];
                  if (slot == ROM_SLOT) begin
                     w = val & (keep | 32'd1);
                  end else begin
                     w = (val & keep) | {24'd0, f[13:6]};
                  end
                  for (int i = 0; i < LANES; i++) begin
                     a = 9'(addr) + 9'(i);
                     if (a < SPACE_BYTES && a < 256) space_mem[a[7:0]] = w[8*i +: 8];
                  end
                  r.update = 1'b1;
                  masked = 1'b1;
               end
            end
         end
         if (!masked && n != 3'd0) begin
            for (int i = 0; i < n; i++) begin
               a = 9'(addr) + 9'(i);
               if (!locked_byte(a) && a < SPACE_BYTES && a < 256) begin
                  space_mem[a[7:0]] = val[8*i +: 8];
               end
            end
            if (9'(addr) + 9'(n) > CMD_REG && addr < CMD_REG_END) r.update = 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin
      access_reply_type due;
      access_reply_type got;
      int slips;
      slips = 0;
      if (reset) begin
         for (int i = 0; i < 256; i++) space_mem[i] = 8'h00;
         ident_q = '0;
         class_q = '0;
         kind_q = '0;
         pin_q = '0;
         bar_low_q = '0;
         bar_high_q = '0;
         replies_due.delete();
         errors <= 0;
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IDENTITY: ident_q = csr_data[31:0];
               CSR_CLASS:    class_q = csr_data[31:0];
               CSR_HDR_KIND: kind_q = csr_data[7:0];
               CSR_INT_PIN:  pin_q = csr_data[7:0];
               CSR_BAR_LOW:  bar_low_q = csr_data[BAR_LOW_BITS-1:0];
               CSR_BAR_HIGH: bar_high_q = csr_data[BAR_HIGH_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               $display("%0t: unexpected word, expected none actual %h", $time, rsp_tdata);
               slips++;
            end else begin
               due = replies_due.pop_front();
               if (rsp_tdata[31:0] !== due.read_data) begin
                  $display("%0t: read_data expected %08h actual %08h",
                           $time, due.read_data, rsp_tdata[31:0]);
                  slips++;
               end
               if (rsp_tdata[32] !== due.update) begin
                  $display("%0t: mappings_update expected %0b actual %0b",
                           $time, due.update, rsp_tdata[32]);
                  slips++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_access(req_tuser, req_tdata[7:0], req_tdata[39:8], req_tdata[42:40], got);
            replies_due.push_back(got);
         end
         errors <= errors + slips;
         pending <= replies_due.size();
      end
   end

endmodule

// ===== tb/pci_config_space_write_mask_top_tb.sv =====
// Testbench top for pci_config_space_write_mask_top: clock, reset, stimulus, verdict.
// Directed accesses, then random ones across several register setups.
// Depends on pcs_pkg, the block and pcs_access_checker.
module pci_config_space_write_mask_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pcs_pkg::*;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ = 1'b1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   int  failures;
   int  pending;
   int  quiet = 0;
   bit  idle_on = 1'b1;

   pci_config_space_write_mask_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   pcs_access_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .errors(failures), .pending(pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= (idle_on && $urandom_range(99) < 31) ? 1'b0 : 1'b1;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
         $display("pci_config_space_write_mask_top: mismatch");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send_access(input logic cmd, input logic [7:0] addr,
                              input logic [31:0] value, input logic [2:0] len);
      if (idle_on && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 31);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {5'd0, len, value, addr};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending and let every outstanding word come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] ident, input logic [31:0] class_w,
                            input logic [7:0] kind, input logic [7:0] pin,
                            input logic [BAR_LOW_BITS-1:0] bar_low,
                            input logic [BAR_HIGH_BITS-1:0] bar_high);
      drain();
      csr_write(CSR_IDENTITY, CSR_DATA_BITS'({$urandom, ident}));
      csr_write(CSR_CLASS, CSR_DATA_BITS'({$urandom, class_w}));
      csr_write(CSR_HDR_KIND, CSR_DATA_BITS'({$urandom, $urandom, kind}));
      csr_write(CSR_INT_PIN, CSR_DATA_BITS'({$urandom, $urandom, pin}));
      csr_write(CSR_BAR_LOW, bar_low);
      csr_write(CSR_BAR_HIGH, CSR_DATA_BITS'(bar_high));
   endtask

   function automatic logic [REGION_BITS-1:0] region(input logic [5:0] code,
                                                     input logic [7:0] attr);
      return {attr, code};
   endfunction

   function automatic logic [REGION_BITS-1:0] random_region();
      int pick;
      logic [5:0] code;
      pick = $urandom_range(9);
      if (pick < 2) code = 6'd0;
      else if (pick < 8) code = 6'($urandom_range(1, 33));
      else if (pick < 9) code = 6'($urandom_range(34, 63));
      else code = 6'($urandom);
      return region(code, 8'($urandom));
   endfunction

   task automatic random_setup();
      logic [7:0] kind;
      int pick;
      pick = $urandom_range(2);
      kind = (pick == 0) ? KIND_DEVICE : (pick == 1) ? KIND_DEVICE_MF : 8'($urandom);
      configure($urandom, $urandom, kind, 8'($urandom),
                {random_region(), random_region(), random_region(), random_region()},
                {random_region(), random_region(), random_region()});
   endtask

   task automatic random_phase(input int count);
      int sent;
      int pick;
      logic [7:0] addr;
      logic [7:0] back;
      logic [2:0] len;
      logic [31:0] value;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            addr = ($urandom_range(5) < 5) ? 8'(BAR_BASE + 4 * $urandom_range(NUM_BARS - 1))
                                           : ROM_BASE;
            if ($urandom_range(3) == 0) addr = addr + 8'($urandom_range(3));
         end else if (pick < 60) begin
            addr = 8'($urandom_range(8'h3f));
         end else if (pick < 70) begin
            addr = 8'($urandom_range(8'hf8, 8'hff));
         end else begin
            addr = 8'($urandom);
         end
         pick = $urandom_range(9);
         len = (pick < 5) ? LEN_FULL : (pick < 8) ? 3'($urandom_range(1, 3))
                                                  : 3'($urandom_range(7));
         value = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF : $urandom;
         if ($urandom_range(9) < 6) begin
            back = ($urandom_range(2) == 0) ? (addr & 8'hfc) : addr;
            send_access(CMD_WRITE, addr, value, len);
            send_access(CMD_READ, back, $urandom, 3'($urandom));
            sent += 2;
         end else begin
            send_access(1'($urandom), addr, value, len);
            sent++;
         end
         if ($urandom_range(63) == 0) drain();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_write(CSR_UNUSED, '1);
      configure(32'h1234_abcd, 32'h0c03_3001, KIND_DEVICE, 8'h01,
                {region(6'd40, 8'h0c), region(6'd0, 8'hff),
                 region(6'd1, 8'h01), region(6'd13, 8'h08)},
                {region(6'd12, 8'hff), region(6'd33, 8'h04), region(6'd32, 8'h00)});

      send_access(CMD_WRITE, 8'h10, 32'hFFFF_FFFF, LEN_FULL);
      send_access(CMD_WRITE, 8'h14, 32'hFFFF_FFFF, LEN_FULL);
      send_access(CMD_WRITE, 8'h18, 32'hFFFF_FFFF, LEN_FULL);
      send_access(CMD_WRITE, 8'h1c, 32'hFFFF_FFFF, LEN_FULL);
      send_access(CMD_WRITE, 8'h20, 32'hFFFF_FFFF, LEN_FULL);
      send_access(CMD_WRITE, 8'h30, 32'hFFFF_FFFF, LEN_FULL);
      send_access(CMD_READ, 8'h10, 32'h0, LEN_FULL);
      send_access(CMD_READ, 8'h14, 32'h0, LEN_FULL);
      send_access(CMD_READ, 8'h1c, 32'h0, LEN_FULL);
      send_access(CMD_READ, 8'h20, 32'h0, LEN_FULL);
      send_access(CMD_READ, 8'h30, 32'h0, LEN_FULL);
      // unaligned masked write lands at the given address
      send_access(CMD_WRITE, 8'h11, 32'hA5A5_5A5A, LEN_FULL);
      send_access(CMD_READ, 8'h10, 32'h0, LEN_FULL);
      send_access(CMD_WRITE, 8'h03, 32'hFFFF_FFFF, 3'd2);
      send_access(CMD_WRITE, 8'h06, 32'h0000_00ff, 3'd1);
      send_access(CMD_READ, 8'h04, 32'h0, LEN_FULL);
      // writes running off the top of the space
      send_access(CMD_WRITE, 8'hfe, 32'h8765_4321, LEN_FULL);
      send_access(CMD_READ, 8'hfd, 32'h0, LEN_FULL);
      send_access(CMD_WRITE, 8'h40, 32'h1122_3344, 3'd0);
      send_access(CMD_WRITE, 8'h44, 32'h5566_7788, 3'd7);
      send_access(CMD_READ, 8'h40, 32'h0, LEN_FULL);
      send_access(CMD_READ, 8'h44, 32'h0, LEN_FULL);
      send_access(CMD_READ, 8'h00, 32'h0, LEN_FULL);
      send_access(CMD_READ, 8'h08, 32'h0, LEN_FULL);
      send_access(CMD_WRITE, 8'h3c, 32'hFFFF_FFFF, LEN_FULL);
      send_access(CMD_READ, 8'h3c, 32'h0, LEN_FULL);
      send_access(CMD_READ, 8'h0c, 32'h0, LEN_FULL);

      configure('1, '1, 8'hff, 8'hff, '1, '1);
      random_phase(60);
      configure('0, '0, KIND_DEVICE, 8'h00, '0, '0);
      random_phase(60);
      for (int p = 0; p < 4; p++) begin
         random_setup();
         idle_on = (p != 2);
         random_phase(130);
      end
      idle_on = 1'b1;

      drain();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("pci_config_space_write_mask_top: match");
      end else begin
         $display("pci_config_space_write_mask_top: mismatch");
      end
      $finish;
   end

endmodule
